FILE: hdl/block_chain_allocator_core_assert.svh
// Assertion macros for the block chain allocator core.
// Used by the top level only; needs no package.
`ifndef BLOCK_CHAIN_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_CHAIN_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bca assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define BCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bca assertion failed");
`else
`define BCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/bca_pkg.sv
// Shared types and constants of the block chain allocator: control word,
// condition flags, action and status codes, and the microcode program ROM.
// No dependencies.
package bca_pkg;

    // Micro program counter.
    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // Request action codes.
    localparam logic [2:0] ACT_NEXT   = 3'd0;
    localparam logic [2:0] ACT_EXTEND = 3'd1;
    localparam logic [2:0] ACT_FIRST  = 3'd2;
    localparam logic [2:0] ACT_FREE   = 3'd3;
    localparam logic [2:0] ACT_LENGTH = 3'd4;
    localparam logic [2:0] ACT_LOCATE = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_OVERREAD = 2'd2;
    localparam logic [1:0] ST_LIMIT    = 2'd3;

    // Datapath operations selected by the control word.
    typedef enum logic [4:0] {
        OP_NOP           = 5'd0,
        OP_CLR           = 5'd1,
        OP_FINISH        = 5'd2,
        OP_SET_NONE      = 5'd3,
        OP_SET_LIMIT     = 5'd4,
        OP_SET_OVR       = 5'd5,
        OP_RD_CUR        = 5'd6,
        OP_RES_LINK      = 5'd7,
        OP_SCAN_INIT_CUR = 5'd8,
        OP_SCAN_INIT_ALL = 5'd9,
        OP_SCAN          = 5'd10,
        OP_ALLOC_FREE    = 5'd11,
        OP_LINK_CUR      = 5'd12,
        OP_RES_FREE      = 5'd13,
        OP_FREE_ADV      = 5'd14,
        OP_LEN_ADV       = 5'd15,
        OP_RES_LOC       = 5'd16,
        OP_LOC_ADV       = 5'd17
    } op_t;

    // Branch conditions tested by the sequencer.
    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_LINK_END  = 3'd1,
        C_SCAN_BUSY = 3'd2,
        C_SCAN_HIT  = 3'd3,
        C_LIMIT     = 3'd4,
        C_OFF_LT    = 3'd5,
        C_OUT_BUSY  = 3'd6,
        C_CLR_LAST  = 3'd7
    } cond_t;

    // One microcode word: operation, condition, taken and fall targets.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  tgt_t;
        upc_t  tgt_f;
    } ctl_t;

    // Status flags from the datapath back to the sequencer.
    typedef struct packed {
        logic link_end;
        logic scan_busy;
        logic scan_hit;
        logic steps_limit;
        logic off_lt;
        logic out_busy;
        logic clr_last;
    } flags_t;

    // Program addresses.
    localparam upc_t U_IDLE = 5'd0;
    localparam upc_t U_CLR  = 5'd1;
    localparam upc_t U_FIN  = 5'd2;
    localparam upc_t U_NONE = 5'd3;
    localparam upc_t U_LIM  = 5'd4;
    localparam upc_t U_OVR  = 5'd5;
    localparam upc_t U_N0   = 5'd6;
    localparam upc_t U_N1   = 5'd7;
    localparam upc_t U_E0   = 5'd8;
    localparam upc_t U_E1   = 5'd9;
    localparam upc_t U_E2   = 5'd10;
    localparam upc_t U_E3   = 5'd11;
    localparam upc_t U_E4   = 5'd12;
    localparam upc_t U_E5   = 5'd13;
    localparam upc_t U_E6   = 5'd14;
    localparam upc_t U_F0   = 5'd15;
    localparam upc_t U_F1   = 5'd16;
    localparam upc_t U_F2   = 5'd17;
    localparam upc_t U_R0   = 5'd18;
    localparam upc_t U_R1   = 5'd19;
    localparam upc_t U_R2   = 5'd20;
    localparam upc_t U_L0   = 5'd21;
    localparam upc_t U_L1   = 5'd22;
    localparam upc_t U_L2   = 5'd23;
    localparam upc_t U_P0   = 5'd24;
    localparam upc_t U_P1   = 5'd25;
    localparam upc_t U_P2   = 5'd26;

    function automatic ctl_t cw(op_t op, cond_t cond, upc_t tgt_t, upc_t tgt_f);
        ctl_t w;
        w.op    = op;
        w.cond  = cond;
        w.tgt_t = tgt_t;
        w.tgt_f = tgt_f;
        return w;
    endfunction

    // The microcode program.
    function automatic ctl_t ucode_rom(upc_t addr);
        ctl_t w;
        unique case (addr)
            U_IDLE: w = cw(OP_NOP, C_ALWAYS, U_IDLE, U_IDLE);
            // Clearing pass after reset: one table entry per cycle.
            U_CLR:  w = cw(OP_CLR, C_CLR_LAST, U_IDLE, U_CLR);
            // Hand over the result, waiting while the output register is full.
            U_FIN:  w = cw(OP_FINISH, C_OUT_BUSY, U_FIN, U_IDLE);
            U_NONE: w = cw(OP_SET_NONE, C_ALWAYS, U_FIN, U_FIN);
            U_LIM:  w = cw(OP_SET_LIMIT, C_ALWAYS, U_FIN, U_FIN);
            U_OVR:  w = cw(OP_SET_OVR, C_ALWAYS, U_FIN, U_FIN);
            // Read a block's link.
            U_N0:   w = cw(OP_RD_CUR, C_ALWAYS, U_N1, U_N1);
            U_N1:   w = cw(OP_RES_LINK, C_LINK_END, U_NONE, U_FIN);
            // Extend: existing link, else scan for a free block and link it.
            U_E0:   w = cw(OP_RD_CUR, C_ALWAYS, U_E1, U_E1);
            U_E1:   w = cw(OP_RES_LINK, C_LINK_END, U_E2, U_FIN);
            U_E2:   w = cw(OP_SCAN_INIT_CUR, C_ALWAYS, U_E3, U_E3);
            U_E3:   w = cw(OP_SCAN, C_SCAN_BUSY, U_E3, U_E4);
            U_E4:   w = cw(OP_NOP, C_SCAN_HIT, U_E5, U_NONE);
            U_E5:   w = cw(OP_ALLOC_FREE, C_ALWAYS, U_E6, U_E6);
            U_E6:   w = cw(OP_LINK_CUR, C_ALWAYS, U_FIN, U_FIN);
            // First free block.
            U_F0:   w = cw(OP_SCAN_INIT_ALL, C_ALWAYS, U_F1, U_F1);
            U_F1:   w = cw(OP_SCAN, C_SCAN_BUSY, U_F1, U_F2);
            U_F2:   w = cw(OP_RES_FREE, C_SCAN_HIT, U_FIN, U_NONE);
            // Free a chain.
            U_R0:   w = cw(OP_RD_CUR, C_ALWAYS, U_R1, U_R1);
            U_R1:   w = cw(OP_FREE_ADV, C_LINK_END, U_FIN, U_R2);
            U_R2:   w = cw(OP_RD_CUR, C_LIMIT, U_LIM, U_R1);
            // Chain length.
            U_L0:   w = cw(OP_RD_CUR, C_ALWAYS, U_L1, U_L1);
            U_L1:   w = cw(OP_LEN_ADV, C_LINK_END, U_FIN, U_L2);
            U_L2:   w = cw(OP_RD_CUR, C_LIMIT, U_LIM, U_L1);
            // Locate a byte offset.
            U_P0:   w = cw(OP_RES_LOC, C_OFF_LT, U_FIN, U_P1);
            U_P1:   w = cw(OP_RD_CUR, C_LIMIT, U_LIM, U_P2);
            U_P2:   w = cw(OP_LOC_ADV, C_LINK_END, U_OVR, U_P0);
            default: w = cw(OP_NOP, C_ALWAYS, U_IDLE, U_IDLE);
        endcase
        return w;
    endfunction

    // Program entry for an accepted request.
    function automatic upc_t entry_of(logic [2:0] action, logic in_range);
        upc_t e;
        if (action == ACT_FIRST) begin
            e = U_F0;
        end else if (!in_range) begin
            e = U_NONE;
        end else begin
            unique case (action)
                ACT_NEXT:   e = U_N0;
                ACT_EXTEND: e = U_E0;
                ACT_FREE:   e = U_R0;
                ACT_LENGTH: e = U_L0;
                ACT_LOCATE: e = U_P0;
                default:    e = U_NONE;
            endcase
        end
        return e;
    endfunction

endpackage

FILE: hdl/bca_sequencer.sv
// Microcode sequencer: micro program counter, program ROM and branch logic.
// Depends on bca_pkg.
module bca_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [2:0]      action,
    input  logic            in_range,
    input  bca_pkg::flags_t flags,
    output bca_pkg::ctl_t   ctl,
    output logic            idle
);
    import bca_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic taken;

    // Current control word.
    assign ctl  = ucode_rom(upc_reg);
    assign idle = (upc_reg == U_IDLE);

    // Branch condition select.
    always_comb begin
        unique case (ctl.cond)
            C_ALWAYS:    taken = 1'b1;
            C_LINK_END:  taken = flags.link_end;
            C_SCAN_BUSY: taken = flags.scan_busy;
            C_SCAN_HIT:  taken = flags.scan_hit;
            C_LIMIT:     taken = flags.steps_limit;
            C_OFF_LT:    taken = flags.off_lt;
            C_OUT_BUSY:  taken = flags.out_busy;
            C_CLR_LAST:  taken = flags.clr_last;
            default:     taken = 1'b1;
        endcase
    end

    // Next step: dispatch on a new request, otherwise follow the word.
    always_comb begin
        if (idle && accept) begin
            upc_next = entry_of(action, in_range);
        end else if (taken) begin
            upc_next = ctl.tgt_t;
        end else begin
            upc_next = ctl.tgt_f;
        end
    end

    // Reset starts the table clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_CLR;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: hdl/bca_datapath.sv
// Datapath: allocation table memory, walk registers, free-block scan and
// the output register. Driven by the microcode word; depends on bca_pkg.
module bca_datapath #(
    parameter int BLOCK_COUNT = 256,
    parameter int BLOCK_BYTES = 512
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  bca_pkg::ctl_t   ctl,
    input  logic            load,
    input  logic [7:0]      block_index,
    input  logic [16:0]     byte_offset,
    input  logic            m_ready,
    output bca_pkg::flags_t flags,
    output logic            m_valid,
    output logic [7:0]      m_result_block,
    output logic [8:0]      m_inner_offset,
    output logic [17:0]     m_chain_bytes,
    output logic [1:0]      m_status
);
    import bca_pkg::*;

    localparam int AW = $clog2(BLOCK_COUNT);
    localparam int LW = $clog2(BLOCK_COUNT + 1);
    localparam int MW = LW + 1;
    localparam logic [LW-1:0] END_LINK  = LW'(BLOCK_COUNT);
    localparam logic [AW-1:0] LAST_IDX  = AW'(BLOCK_COUNT - 1);
    localparam logic [LW-1:0] STEP_MAX  = LW'(BLOCK_COUNT);
    localparam logic [16:0]   BB_OFF    = 17'(BLOCK_BYTES);
    localparam logic [18:0]   BB_SUM    = 19'(BLOCK_BYTES);
    localparam logic [18:0]   BYTES_MAX = 19'h3FFFF;

    // Table entry: in-use bit over the next link.
    logic [MW-1:0] mem [BLOCK_COUNT];
    logic [MW-1:0] rd_reg;

    logic [AW-1:0] cur_reg;
    logic [16:0]   off_reg;
    logic [LW-1:0] steps_reg;
    logic [17:0]   bytes_reg;
    logic [7:0]    res_reg;
    logic [8:0]    inner_reg;
    logic [1:0]    stat_reg;
    logic [AW-1:0] free_reg;
    logic [LW-1:0] skip_reg;
    logic [AW-1:0] scan_reg;
    logic [AW-1:0] cand_reg;
    logic          scan_vld_reg;
    logic          found_reg;
    logic          m_valid_reg;
    logic [7:0]    out_block_reg;
    logic [8:0]    out_inner_reg;
    logic [17:0]   out_bytes_reg;
    logic [1:0]    out_stat_reg;

    logic          rd_used;
    logic [LW-1:0] rd_raw;
    logic [AW-1:0] rd_idx;
    logic          link_end;
    logic          hit_now;
    logic          last_now;
    logic          out_busy;
    logic          we;
    logic [AW-1:0] waddr;
    logic [MW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [18:0]   bytes_sum;
    logic [17:0]   bytes_next;
    logic [16:0]   off_next;

    // Decode of the registered table read.
    assign rd_used  = rd_reg[MW-1];
    assign rd_raw   = rd_reg[LW-1:0];
    assign rd_idx   = rd_raw[AW-1:0];
    assign link_end = (rd_raw >= END_LINK);

    // Scan compare on the entry read in the previous cycle.
    assign hit_now  = scan_vld_reg && !rd_used && (LW'(cand_reg) != skip_reg);
    assign last_now = scan_vld_reg && (cand_reg == LAST_IDX);
    assign out_busy = m_valid_reg && !m_ready;

    // Length accumulation saturates at the field maximum.
    assign bytes_sum  = 19'(bytes_reg) + BB_SUM;
    assign bytes_next = (bytes_sum > BYTES_MAX) ? BYTES_MAX[17:0] : bytes_sum[17:0];
    assign off_next   = off_reg - BB_OFF;

    assign flags.link_end    = link_end;
    assign flags.scan_busy   = !(hit_now || last_now);
    assign flags.scan_hit    = found_reg;
    assign flags.steps_limit = (steps_reg == STEP_MAX);
    assign flags.off_lt      = (off_reg < BB_OFF);
    assign flags.out_busy    = out_busy;
    assign flags.clr_last    = (scan_reg == LAST_IDX);

    // Table write port selection.
    always_comb begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = {1'b0, END_LINK};
        unique case (ctl.op)
            OP_CLR: begin
                we    = 1'b1;
                waddr = scan_reg;
            end
            OP_ALLOC_FREE: begin
                we    = 1'b1;
                waddr = free_reg;
                wdata = {1'b1, END_LINK};
            end
            OP_LINK_CUR: begin
                we    = 1'b1;
                wdata = {1'b1, LW'(free_reg)};
            end
            OP_FREE_ADV: begin
                we    = 1'b1;
            end
            default: begin
                we    = 1'b0;
            end
        endcase
    end

    assign raddr = (ctl.op == OP_SCAN) ? scan_reg : cur_reg;

    // Allocation table: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // Scan and clearing counters, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg     <= '0;
            cand_reg     <= '0;
            scan_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            unique case (ctl.op)
                OP_CLR: begin
                    scan_reg <= scan_reg + 1'b1;
                end
                OP_SCAN_INIT_CUR, OP_SCAN_INIT_ALL: begin
                    scan_reg     <= '0;
                    scan_vld_reg <= 1'b0;
                    found_reg    <= 1'b0;
                end
                OP_SCAN: begin
                    scan_reg     <= scan_reg + 1'b1;
                    cand_reg     <= scan_reg;
                    scan_vld_reg <= 1'b1;
                    if (hit_now) begin
                        found_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (ctl.op == OP_FINISH && !out_busy) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk registers, loaded on a new request and stepped by the microcode.
    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg   <= AW'(block_index);
            off_reg   <= byte_offset;
            steps_reg <= '0;
            bytes_reg <= '0;
            res_reg   <= '0;
            inner_reg <= '0;
            stat_reg  <= ST_OK;
        end else begin
            unique case (ctl.op)
                OP_SET_NONE:      stat_reg <= ST_NONE;
                OP_SET_LIMIT:     stat_reg <= ST_LIMIT;
                OP_SET_OVR:       stat_reg <= ST_OVERREAD;
                OP_RES_LINK:      res_reg  <= 8'(rd_raw);
                OP_SCAN_INIT_CUR: skip_reg <= LW'(cur_reg);
                OP_SCAN_INIT_ALL: skip_reg <= END_LINK;
                OP_SCAN: begin
                    if (hit_now) begin
                        free_reg <= cand_reg;
                    end
                end
                OP_LINK_CUR:      res_reg  <= 8'(free_reg);
                OP_RES_FREE:      res_reg  <= 8'(free_reg);
                OP_FREE_ADV: begin
                    cur_reg   <= rd_idx;
                    steps_reg <= steps_reg + 1'b1;
                end
                OP_LEN_ADV: begin
                    bytes_reg <= bytes_next;
                    cur_reg   <= rd_idx;
                    steps_reg <= steps_reg + 1'b1;
                end
                OP_RES_LOC: begin
                    res_reg   <= 8'(cur_reg);
                    inner_reg <= off_reg[8:0];
                end
                OP_LOC_ADV: begin
                    off_reg   <= off_next;
                    cur_reg   <= rd_idx;
                    steps_reg <= steps_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register; every field but status reads zero on an error.
    always_ff @(posedge aclk) begin
        if (ctl.op == OP_FINISH && !out_busy) begin
            out_stat_reg <= stat_reg;
            if (stat_reg == ST_OK) begin
                out_block_reg <= res_reg;
                out_inner_reg <= inner_reg;
                out_bytes_reg <= bytes_reg;
            end else begin
                out_block_reg <= '0;
                out_inner_reg <= '0;
                out_bytes_reg <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_block = out_block_reg;
    assign m_inner_offset = out_inner_reg;
    assign m_chain_bytes  = out_bytes_reg;
    assign m_status       = out_stat_reg;

endmodule

FILE: hdl/block_chain_allocator_core.sv
// Top level of the block chain allocator: microcode sequencer plus datapath.
// Depends on bca_pkg, bca_sequencer, bca_datapath and the assertion header.
//
//   Channel  Direction  Handshake         Beat fields
//   s_       in         s_valid/s_ready   action, block_index, byte_offset
//   m_       out        m_valid/m_ready   result_block, inner_offset,
//                                         chain_bytes, status
//
// Reset: the table is cleared one entry per cycle, with s_ready low.
// One request at a time; scans read one table entry per cycle, and walks read
// a block's link and then advance along the chain one block at a time.
// s_ready rises with m_valid; only a result still held stalls the next hand-over.
`include "block_chain_allocator_core_assert.svh"

module block_chain_allocator_core #(
    parameter int BLOCK_COUNT = 256,
    parameter int BLOCK_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [7:0]  s_block_index,
    input  logic [16:0] s_byte_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_result_block,
    output logic [8:0]  m_inner_offset,
    output logic [17:0] m_chain_bytes,
    output logic [1:0]  m_status
);
    import bca_pkg::*;

    ctl_t   ctl;
    flags_t flags;
    logic   idle;
    logic   accept;
    logic   in_range;

    assign s_ready  = idle;
    assign accept   = s_valid && s_ready;
    assign in_range = (int'(s_block_index) < BLOCK_COUNT);

    // Control program.
    bca_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .action   (s_action),
        .in_range (in_range),
        .flags    (flags),
        .ctl      (ctl),
        .idle     (idle)
    );

    // Table and walk datapath.
    bca_datapath #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .load           (accept),
        .block_index    (s_block_index),
        .byte_offset    (s_byte_offset),
        .m_ready        (m_ready),
        .flags          (flags),
        .m_valid        (m_valid),
        .m_result_block (m_result_block),
        .m_inner_offset (m_inner_offset),
        .m_chain_bytes  (m_chain_bytes),
        .m_status       (m_status)
    );

    // A request always takes at least one program step.
    `BCA_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, !s_ready)
    // The clearing pass neither takes requests nor shows results.
    `BCA_ASSERT_IMPL(a_clear_quiet, aclk, aresetn, ctl.op == OP_CLR, !m_valid && !s_ready)
    // An error result carries zeros in every other field.
    `BCA_ASSERT_IMPL(a_error_zeroes, aclk, aresetn,
        m_valid && (m_status != ST_OK),
        (m_result_block == 8'd0) && (m_inner_offset == 9'd0) && (m_chain_bytes == 18'd0))
    // Handing over waits while the output register is still full.
    `BCA_ASSERT_NEXT(a_finish_waits, aclk, aresetn,
        (ctl.op == OP_FINISH) && m_valid && !m_ready, ctl.op == OP_FINISH)

endmodule
